// File: rtl/heart_rate_peak_interval_estimator_macros.svh
// Assertion macros for the heart rate estimator checker.
// Used by heart_rate_peak_interval_estimator_checker.sv only; expects aclk and aresetn in scope.
`ifndef HEART_RATE_PEAK_INTERVAL_ESTIMATOR_MACROS_SVH
`define HEART_RATE_PEAK_INTERVAL_ESTIMATOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define HR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent.
`define HR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hrpie_pkg.sv
// Shared types and constants for the heart rate estimator.
// No dependencies.
package hrpie_pkg;

    typedef struct packed {
        logic [17:0] red_sample;
        logic [31:0] time_ms;
    } hrpie_in_t;

    typedef struct packed {
        logic [9:0]         heart_rate;
        logic               rate_valid;
        logic               peak_found;
        logic signed [15:0] threshold_now;
    } hrpie_out_t;

    localparam logic [2:0] REG_INIT_THR  = 3'd0;
    localparam logic [2:0] REG_BAND_LOW  = 3'd1;
    localparam logic [2:0] REG_BAND_HIGH = 3'd2;
    localparam logic [2:0] REG_FRACTION  = 3'd3;
    localparam logic [2:0] REG_WINDOW    = 3'd4;
    localparam logic [2:0] REG_WARMUP    = 3'd5;

    localparam logic [9:0] RATE_NONE = 10'd999;
    localparam logic [9:0] RATE_MAX  = 10'd998;
    localparam logic [15:0] MS_PER_MIN = 16'd60000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIP,
        ST_MUL,
        ST_THR_DIV,
        ST_RD_ENDS,
        ST_WAIT_ENDS,
        ST_RATE_MUL,
        ST_RATE_DIV,
        ST_EXPIRE_RD,
        ST_EXPIRE_CHK,
        ST_OUT
    } hrpie_state_t;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [63:0] divisor;
    } hrpie_div_req_t;

endpackage

// File: rtl/hrpie_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module hrpie_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/hrpie_div.sv
// Radix-2 restoring divider for unsigned 64-bit operands, one bit a cycle.
// Depends on hrpie_pkg.
module hrpie_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  hrpie_pkg::hrpie_div_req_t req,
    output logic                     done,
    output logic [63:0]              quotient
);
    import hrpie_pkg::*;

    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, dsr_reg};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// File: rtl/heart_rate_peak_interval_estimator.sv
// Heart rate estimator: one request is taken at a time and gives one result.
// A cold request with no accepted dip goes straight from the dip check to the
// output state. The shared 64-bit bit-serial divider serves both the threshold
// and the rate division: a warm sample reads the oldest stamp, runs the rate
// division when two or more stamps span a nonzero time, and then the expiry
// check; an accepted dip first runs the threshold division; and the expiry walk
// reads the ring memory through its registered read port for every stamp that
// it checks. A finished result may wait in the output register while the next
// request is taken; a later result holds until that register drains. Register
// writes are taken only while no request is in flight. No clearing pass after
// reset. Depends on hrpie_pkg, hrpie_ram and hrpie_div.
module heart_rate_peak_interval_estimator #(
    parameter int RING_DEPTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  hrpie_pkg::hrpie_in_t   s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output hrpie_pkg::hrpie_out_t  m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [15:0]            cfg_data
);
    import hrpie_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);

    // configuration
    logic signed [15:0] init_thr_reg, band_low_reg, band_high_reg;
    logic [10:0] frac_reg;
    logic [15:0] window_reg, warmup_reg;

    // state
    hrpie_state_t state_reg, state_next;
    logic [17:0] prev_reg;
    logic signed [15:0] dip_min_reg, thr_reg;
    logic signed [47:0] sum_reg;
    logic [31:0] count_reg;
    logic [AW-1:0] head_reg;
    logic [FW-1:0] fill_reg;
    logic [9:0] rate_reg;
    logic warm_reg, started_reg;
    logic [31:0] start_reg;
    // last pushed stamp, the tail of the ring while the ring is not empty
    logic [31:0] newest_reg;

    // per-request
    hrpie_in_t in_reg;
    logic peak_reg;
    logic [63:0] prod_reg;
    logic neg_reg;
    logic [31:0] oldest_reg;
    hrpie_out_t out_reg;
    logic out_valid_reg;

    logic s_fire, m_fire, cfg_fire, out_load;
    logic signed [15:0] diff;

    // ring
    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0] ram_rdata;

    hrpie_div_req_t div_req;
    logic div_done;
    logic [63:0] div_q;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = out_valid_reg && m_ready;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || m_fire);
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    assign diff = $signed(in_reg.red_sample[15:0] - prev_reg[15:0]);

    function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] h,
                                               input logic [FW-1:0] off);
        logic [FW:0] s;
        s = {1'b0, FW'(h)} + {1'b0, off};
        if (s >= (FW+1)'(RING_DEPTH)) begin
            s = s - (FW+1)'(RING_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    hrpie_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_reg.time_ms),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    hrpie_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    logic dip_close, dip_accept, push_full;
    assign dip_close  = !(diff < thr_reg) && (dip_min_reg < 0);
    assign dip_accept = dip_close && (dip_min_reg > band_low_reg)
                        && (dip_min_reg < band_high_reg);
    assign push_full  = (fill_reg == FW'(RING_DEPTH));

    logic [31:0] span;
    assign span = newest_reg - oldest_reg;

    logic [31:0] age;
    assign age = in_reg.time_ms - ram_rdata;

    logic warm_now;
    assign warm_now = warm_reg ||
        ((in_reg.time_ms - (started_reg ? start_reg : in_reg.time_ms)) >= {16'd0, warmup_reg});

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (s_fire) state_next = ST_DIP;
            ST_DIP:        state_next = dip_accept ? ST_MUL :
                                        (warm_now ? ST_RD_ENDS : ST_OUT);
            ST_MUL:        state_next = ST_THR_DIV;
            ST_THR_DIV:    if (div_done) state_next = warm_reg ? ST_RD_ENDS : ST_OUT;
            ST_RD_ENDS:    state_next = ST_WAIT_ENDS;
            ST_WAIT_ENDS:  state_next = (fill_reg < FW'(2)) ? ST_EXPIRE_RD :
                                        ((newest_reg - ram_rdata) == 32'd0 ?
                                         ST_EXPIRE_RD : ST_RATE_MUL);
            ST_RATE_MUL:   state_next = ST_RATE_DIV;
            ST_RATE_DIV:   if (div_done) state_next = ST_EXPIRE_RD;
            ST_EXPIRE_RD:  state_next = (fill_reg == '0) ? ST_OUT : ST_EXPIRE_CHK;
            ST_EXPIRE_CHK: state_next = (age > {16'd0, window_reg}) ? ST_EXPIRE_RD : ST_OUT;
            ST_OUT:        if (out_load) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // outputs toward memory and divider
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ring_idx(head_reg, fill_reg);
        ram_raddr = head_reg;
        div_req   = '0;
        case (state_reg)
            ST_DIP: begin
                if (dip_accept) begin
                    ram_we    = 1'b1;
                    ram_waddr = push_full ? head_reg : ring_idx(head_reg, fill_reg);
                end
            end
            ST_THR_DIV: begin
                div_req.start    = 1'b0;
            end
            ST_MUL: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = {22'd0, count_reg, 10'd0};
            end
            ST_RATE_MUL: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod_reg;
                div_req.divisor  = {32'd0, span};
            end
            default: ;
        endcase
    end

    // signed threshold dividend after sum update, and the signed quotient; a saturated
    // count keeps the old sum but still recomputes the threshold
    logic signed [47:0] sum_new, sum_used;
    logic signed [59:0] sprod;
    logic [63:0] q_mag;
    logic signed [64:0] q_s;
    always_comb begin
        sum_new  = sum_reg + 48'(dip_min_reg);
        sum_used = (count_reg != '1) ? sum_new : sum_reg;
        sprod    = 60'(sum_used) * $signed({1'b0, frac_reg});
        q_mag    = div_q;
        q_s      = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            init_thr_reg  <= -16'sd40;
            band_low_reg  <= -16'sd3000;
            band_high_reg <= -16'sd100;
            frac_reg      <= 11'd410;
            window_reg    <= 16'd8000;
            warmup_reg    <= 16'd8000;
            prev_reg      <= '0;
            dip_min_reg   <= '0;
            thr_reg       <= -16'sd40;
            sum_reg       <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            rate_reg      <= '0;
            warm_reg      <= 1'b0;
            started_reg   <= 1'b0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                case (cfg_index)
                    REG_INIT_THR: begin
                        init_thr_reg <= $signed(cfg_data);
                        if (count_reg == '0) thr_reg <= $signed(cfg_data);
                    end
                    REG_BAND_LOW:  band_low_reg  <= $signed(cfg_data);
                    REG_BAND_HIGH: band_high_reg <= $signed(cfg_data);
                    REG_FRACTION:  frac_reg      <= cfg_data[10:0];
                    REG_WINDOW:    window_reg    <= cfg_data;
                    REG_WARMUP:    warmup_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_fire) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: if (s_fire) in_reg <= s_data;
                ST_DIP: begin
                    if (!started_reg) begin
                        started_reg <= 1'b1;
                        start_reg   <= in_reg.time_ms;
                    end
                    warm_reg <= warm_now;
                    prev_reg <= in_reg.red_sample;
                    peak_reg <= dip_accept;
                    if (diff < thr_reg) begin
                        if (diff < dip_min_reg) dip_min_reg <= diff;
                    end else if (dip_min_reg < 0) begin
                        dip_min_reg <= '0;
                    end
                    if (dip_accept) begin
                        if (push_full) head_reg <= ring_idx(head_reg, FW'(1));
                        else fill_reg <= fill_reg + FW'(1);
                        newest_reg <= in_reg.time_ms;
                        neg_reg    <= sprod < 0;
                        prod_reg   <= sprod < 0 ? 64'(-sprod) : 64'(sprod);
                        if (count_reg != '1) begin
                            count_reg <= count_reg + 32'd1;
                            sum_reg   <= sum_new;
                        end
                    end
                end
                ST_THR_DIV: begin
                    if (div_done) begin
                        if (q_s < -65'sd32768) thr_reg <= -16'sd32768;
                        else if (q_s > 65'sd32767) thr_reg <= 16'sd32767;
                        else thr_reg <= q_s[15:0];
                    end
                end
                ST_RD_ENDS: ;
                ST_WAIT_ENDS: begin
                    oldest_reg <= ram_rdata;
                    prod_reg   <= 64'(MS_PER_MIN) * 64'(fill_reg - FW'(1));
                    if (fill_reg < FW'(2) || (newest_reg - ram_rdata) == 32'd0)
                        rate_reg <= RATE_NONE;
                end
                ST_RATE_DIV: begin
                    if (div_done)
                        rate_reg <= (div_q > 64'(RATE_MAX)) ? RATE_MAX : div_q[9:0];
                end
                ST_EXPIRE_CHK: begin
                    if (age > {16'd0, window_reg}) begin
                        head_reg <= ring_idx(head_reg, FW'(1));
                        fill_reg <= fill_reg - FW'(1);
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        out_reg.heart_rate    <= rate_reg;
                        out_reg.rate_valid    <= warm_reg;
                        out_reg.peak_found    <= peak_reg;
                        out_reg.threshold_now <= thr_reg;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// File: rtl/heart_rate_peak_interval_estimator_checker.sv
// Port-level checker for the heart rate estimator, bound to the top level.
// Depends on hrpie_pkg and the assertion macro header.
`include "heart_rate_peak_interval_estimator_macros.svh"

module heart_rate_peak_interval_estimator_checker (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input hrpie_pkg::hrpie_out_t m_data
);
    import hrpie_pkg::*;

    `HR_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result not held")
    `HR_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second request while busy")
    `HR_ASSERT_IMPL(a_rate_range, m_valid, m_data.heart_rate <= RATE_NONE, "rate out of range")
    `HR_ASSERT_IMPL(a_cold_rate, m_valid && !m_data.rate_valid, m_data.heart_rate == '0, "cold rate")
endmodule

bind heart_rate_peak_interval_estimator heart_rate_peak_interval_estimator_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
